### rtl/gcs_pkg.sv
// gcs_pkg: shared types and constants for the greedy clique search core
`timescale 1ns / 1ps

package gcs_pkg;

    // fixed field widths
    localparam int VERT_W = 6;
    localparam int SIZE_W = 7;
    localparam int OP_W   = 2;
    localparam int ROW_W  = 64;

    // input op codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd2;

    // input beat
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [VERT_W-1:0] vertex_a;
        logic [VERT_W-1:0] vertex_b;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [VERT_W-1:0] member_vertex;
        logic [SIZE_W-1:0] clique_size;
        logic              last;
    } out_beat_t;

    // adjacency memory request
    typedef struct packed {
        logic              clr;
        logic              rd_en;
        logic [VERT_W-1:0] rd_addr;
        logic              wr_en;
        logic [VERT_W-1:0] wr_addr;
        logic [ROW_W-1:0]  wr_data;
    } mem_req_t;

    // start of emission
    typedef struct packed {
        logic              start;
        logic [ROW_W-1:0]  mask;
        logic [SIZE_W-1:0] size;
    } emit_req_t;

    // emitter status
    typedef struct packed {
        logic busy;
    } emit_sts_t;

endpackage

### rtl/gcs_adj_mem.sv
// gcs_adj_mem: adjacency row memory with per-row valid bits and registered read
`timescale 1ns / 1ps

module gcs_adj_mem import gcs_pkg::*; #(
    parameter int VCAP = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  mem_req_t         req,
    output logic [ROW_W-1:0] rd_row
);

    localparam int AW = $clog2(VCAP);

    logic [VCAP-1:0] mem [VCAP];
    logic [VCAP-1:0] rd_data_reg;
    logic            rd_vld_reg;
    logic [VCAP-1:0] vld_reg;
    logic [VCAP-1:0] vld_next;

    // row storage and registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data[VCAP-1:0];
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
            rd_vld_reg  <= vld_reg[req.rd_addr[AW-1:0]];
        end
    end

    // valid bits: cleared at once by reset or clear, set on write
    always_comb begin
        vld_next = vld_reg;
        if (req.clr) begin
            vld_next = '0;
        end else if (req.wr_en) begin
            vld_next[req.wr_addr[AW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // a row never written since clear reads as zero
    assign rd_row = rd_vld_reg ? ROW_W'(rd_data_reg) : '0;

endmodule

### rtl/gcs_ctrl.sv
// gcs_ctrl: op sequencer for edge insertion, clear and the greedy search sweep
`timescale 1ns / 1ps

module gcs_ctrl import gcs_pkg::*; #(
    parameter int VCAP = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_beat_t          s_data,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    output mem_req_t          mem_req,
    input  logic [ROW_W-1:0]  rd_row,
    output emit_req_t         emit_req,
    input  emit_sts_t         emit_sts
);

    localparam int AW = $clog2(VCAP);
    localparam int CW = $clog2(VCAP + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ADD_RA = 3'd1;
    localparam logic [2:0] ST_ADD_WA = 3'd2;
    localparam logic [2:0] ST_ADD_RB = 3'd3;
    localparam logic [2:0] ST_ADD_WB = 3'd4;
    localparam logic [2:0] ST_SCAN   = 3'd5;
    localparam logic [2:0] ST_EVAL   = 3'd6;
    localparam logic [2:0] ST_EMIT   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [SIZE_W-1:0] vcount_reg;
    logic [AW-1:0]     va_reg, va_next;
    logic [AW-1:0]     vb_reg, vb_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [AW-1:0]     v_reg, v_next;
    logic [CW-1:0]     u_reg, u_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_u_reg, pend_u_next;
    logic [VCAP-1:0]   cur_reg, cur_next;
    logic [CW-1:0]     size_reg, size_next;
    logic [VCAP-1:0]   best_reg, best_next;
    logic [CW-1:0]     best_size_reg, best_size_next;

    logic              accept;
    logic              issue;
    logic              better;
    logic [CW-1:0]     n_eff;
    logic [ROW_W-1:0]  bit_b;
    logic [ROW_W-1:0]  bit_a;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // vertex count in use, clamped to 1..capacity
    always_comb begin
        if (vcount_reg == '0) begin
            n_eff = CW'(1);
        end else if (vcount_reg > SIZE_W'(VCAP)) begin
            n_eff = CW'(VCAP);
        end else begin
            n_eff = CW'(vcount_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= SIZE_W'(VCAP);
        end else if (cfg_wr_en) begin
            vcount_reg <= cfg_wr_data;
        end
    end

    assign issue  = (state_reg == ST_SCAN) && (u_reg < n_reg);
    assign better = (size_reg > best_size_reg);
    assign bit_b  = ROW_W'(1) << vb_reg;
    assign bit_a  = ROW_W'(1) << va_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        n_next         = n_reg;
        v_next         = v_reg;
        u_next         = u_reg;
        pend_next      = 1'b0;
        pend_u_next    = pend_u_reg;
        cur_next       = cur_reg;
        size_next      = size_reg;
        best_next      = best_reg;
        best_size_next = best_size_reg;
        mem_req        = '0;
        emit_req       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.op)
                        OP_ADD: begin
                            if ((7'(s_data.vertex_a) < 7'(VCAP)) &&
                                (7'(s_data.vertex_b) < 7'(VCAP))) begin
                                va_next    = s_data.vertex_a[AW-1:0];
                                vb_next    = s_data.vertex_b[AW-1:0];
                                state_next = ST_ADD_RA;
                            end
                        end
                        OP_CLEAR: begin
                            mem_req.clr = 1'b1;
                        end
                        OP_RUN: begin
                            n_next         = n_eff;
                            v_next         = '0;
                            cur_next       = VCAP'(1);
                            size_next      = CW'(1);
                            u_next         = CW'(1);
                            best_next      = '0;
                            best_size_next = '0;
                            state_next     = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADD_RA: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = VERT_W'(va_reg);
                state_next      = ST_ADD_WA;
            end
            ST_ADD_WA: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = VERT_W'(va_reg);
                mem_req.wr_data = rd_row | bit_b;
                state_next      = ST_ADD_RB;
            end
            ST_ADD_RB: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = VERT_W'(vb_reg);
                state_next      = ST_ADD_WB;
            end
            ST_ADD_WB: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = VERT_W'(vb_reg);
                mem_req.wr_data = rd_row | bit_a;
                state_next      = ST_IDLE;
            end
            ST_SCAN: begin
                // issue one row read per cycle, test it the cycle after
                if (issue) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = VERT_W'(u_reg);
                    u_next          = u_reg + CW'(1);
                    pend_next       = 1'b1;
                    pend_u_next     = u_reg[AW-1:0];
                end
                if (pend_reg) begin
                    if ((cur_reg & ~rd_row[VCAP-1:0]) == '0) begin
                        cur_next[pend_u_reg] = 1'b1;
                        size_next            = size_reg + CW'(1);
                    end
                end
                if (!issue && !pend_reg) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // keep the larger clique, earlier start wins ties
                if (better) begin
                    best_next      = cur_reg;
                    best_size_next = size_reg;
                end
                if (CW'(v_reg) == n_reg - CW'(1)) begin
                    emit_req.start = 1'b1;
                    emit_req.mask  = better ? ROW_W'(cur_reg) : ROW_W'(best_reg);
                    emit_req.size  = better ? SIZE_W'(size_reg) : SIZE_W'(best_size_reg);
                    state_next     = ST_EMIT;
                end else begin
                    v_next     = v_reg + AW'(1);
                    cur_next   = VCAP'(1) << (v_reg + AW'(1));
                    size_next  = CW'(1);
                    u_next     = CW'(v_reg) + CW'(2);
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT: begin
                if (!emit_sts.busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        va_reg        <= va_next;
        vb_reg        <= vb_next;
        n_reg         <= n_next;
        v_reg         <= v_next;
        u_reg         <= u_next;
        pend_u_reg    <= pend_u_next;
        cur_reg       <= cur_next;
        size_reg      <= size_next;
        best_reg      <= best_next;
        best_size_reg <= best_size_next;
    end

endmodule

### rtl/gcs_emit.sv
// gcs_emit: streams the best clique's members in ascending order into the output register
`timescale 1ns / 1ps

module gcs_emit import gcs_pkg::*; #(
    parameter int VCAP = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  emit_req_t req,
    output emit_sts_t sts,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int AW = $clog2(VCAP);

    logic              busy_reg;
    logic [VCAP-1:0]   mask_reg;
    logic [AW-1:0]     idx_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] remain_reg;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;
    logic              slot_free;
    logic              hit;
    logic              load;

    assign slot_free = !m_valid_reg || m_ready;
    assign hit       = busy_reg && mask_reg[idx_reg];
    assign load      = hit && slot_free;

    // walk the mask one position per cycle, stall on a member until the slot frees
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
        end else if (load && (remain_reg == SIZE_W'(1))) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            mask_reg   <= req.mask[VCAP-1:0];
            idx_reg    <= '0;
            size_reg   <= req.size;
            remain_reg <= req.size;
        end else if (busy_reg) begin
            if (load) begin
                idx_reg    <= idx_reg + AW'(1);
                remain_reg <= remain_reg - SIZE_W'(1);
            end else if (!hit) begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg.member_vertex <= VERT_W'(idx_reg);
            m_data_reg.clique_size   <= size_reg;
            m_data_reg.last          <= (remain_reg == SIZE_W'(1));
        end
    end

    assign sts.busy = busy_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

endmodule

### rtl/greedy_clique_search_core.sv
// Add edge reads and rewrites the row of vertex a, then that of vertex b; clear is one request
// to the row memory; run searches from each of the n vertices in use, reading one adjacency
// row per cycle from the row memory while scanning, then streams the result beats over up to
// 64 mask positions. One item at a time: the next item is taken once the previous one has
// finished and its last beat is loaded. Reset (aresetn, synchronous, active low) empties the
// graph through per-row valid bits at once, with no clearing pass, and sets the vertex count to capacity.
`timescale 1ns / 1ps

module greedy_clique_search_core import gcs_pkg::*; #(
    parameter int MAX_VERTICES = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_beat_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_beat_t         m_data,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data
);

    localparam int VCAP = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;

    mem_req_t         mem_req;
    logic [ROW_W-1:0] rd_row;
    emit_req_t        emit_req;
    emit_sts_t        emit_sts;

    // adjacency storage
    gcs_adj_mem #(.VCAP(VCAP)) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_row  (rd_row)
    );

    // op sequencer and search
    gcs_ctrl #(.VCAP(VCAP)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mem_req     (mem_req),
        .rd_row      (rd_row),
        .emit_req    (emit_req),
        .emit_sts    (emit_sts)
    );

    // result streaming
    gcs_emit #(.VCAP(VCAP)) u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (emit_req),
        .sts     (emit_sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // a result beat always carries a nonempty clique size
    a_size_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.clique_size != '0))
        else $error("result beat with zero clique size");

    // a beat that is not the last leaves the emitter busy
    a_more_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> emit_sts.busy)
        else $error("emitter idle before last beat");

    // input is only taken once emission has ended
    a_idle_no_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !emit_sts.busy)
        else $error("input ready while clique still streaming");

    // memory never reads and writes in the same cycle
    a_mem_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("adjacency read and write overlap");

    // a start request from the search makes the emitter busy
    a_start_once: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_req.start |=> emit_sts.busy)
        else $error("emitter failed to start");

endmodule
